[rtl/command_line_tokenizer_core_macros.svh]
// Assertion macros shared by the command line tokenizer RTL.
`ifndef COMMAND_LINE_TOKENIZER_CORE_MACROS_SVH
`define COMMAND_LINE_TOKENIZER_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, sampled on clock, off during reset.
`define CTK_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("tokenizer assertion failed");

// Next-cycle implication, sampled on clock, off during reset.
`define CTK_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("tokenizer assertion failed");

`else

`define CTK_ASSERT_IMPL(label, ante, cons)
`define CTK_ASSERT_NEXT(label, ante, cons)

`endif

`endif

[rtl/ctk_pkg.sv]
// Package: constants, codes and types of the command line tokenizer.
`default_nettype none

package ctk_pkg;

   localparam int MaxNumbers    = 4;
   localparam int NumberWidth   = 32;
   localparam int IndexWidth    = $clog2(MaxNumbers + 2);
   localparam int ValueWidth    = 32;
   localparam int OutSlots      = 4;
   localparam int ProductWidth  = NumberWidth + 4;

   localparam logic [NumberWidth-1:0] NumberLimit = '1;

   // line status codes
   localparam logic [1:0] StatusValid   = 2'd0;
   localparam logic [1:0] StatusError   = 2'd1;
   localparam logic [1:0] StatusIgnored = 2'd2;

   // characters of interest
   localparam logic [7:0] ChNewline = 8'd10;
   localparam logic [7:0] ChHash    = 8'd35;
   localparam logic [7:0] ChSpace   = 8'd32;
   localparam logic [7:0] ChTab     = 8'd9;
   localparam logic [7:0] ChVtab    = 8'd11;
   localparam logic [7:0] ChFeed    = 8'd12;
   localparam logic [7:0] ChReturn  = 8'd13;
   localparam logic [7:0] ChZero    = 8'd48;
   localparam logic [7:0] ChNine    = 8'd57;
   localparam logic [7:0] ChUpperA  = 8'd65;
   localparam logic [7:0] ChUpperZ  = 8'd90;
   localparam logic [7:0] ChLowerA  = 8'd97;
   localparam logic [7:0] ChLowerZ  = 8'd122;

   typedef struct packed {
      logic       is_newline;
      logic       is_hash;
      logic       is_alpha;
      logic       is_blank;
      logic       is_numeral;
      logic [3:0] digit;
   } char_class_type;

   typedef struct packed {
      logic [7:0]            command_code;
      logic [ValueWidth-1:0] value_one;
      logic [ValueWidth-1:0] value_two;
      logic [ValueWidth-1:0] value_three;
      logic [ValueWidth-1:0] value_four;
      logic [2:0]            value_count;
      logic [1:0]            line_status;
      logic                  input_ended;
   } result_type;

endpackage

`default_nettype wire

[rtl/ctk_req_if.sv]
// Interface: input channel carrying one byte or an end-of-input mark.
`default_nettype none

interface ctk_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] byte_in;
   logic       end_of_input;

   modport source (output valid, output byte_in, output end_of_input, input ready);
   modport sink (input valid, input byte_in, input end_of_input, output ready);
endinterface

`default_nettype wire

[rtl/ctk_rsp_if.sv]
// Interface: result channel carrying one parsed line.
`default_nettype none

interface ctk_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  command_code;
   logic [31:0] value_one;
   logic [31:0] value_two;
   logic [31:0] value_three;
   logic [31:0] value_four;
   logic [2:0]  value_count;
   logic [1:0]  line_status;
   logic        input_ended;

   modport source (output valid, output command_code, output value_one, output value_two,
                   output value_three, output value_four, output value_count,
                   output line_status, output input_ended, input ready);
   modport sink (input valid, input command_code, input value_one, input value_two,
                 input value_three, input value_four, input value_count,
                 input line_status, input input_ended, output ready);
endinterface

`default_nettype wire

[rtl/command_line_tokenizer_core.sv]
// Top level: command line tokenizer, one character per cycle into parsed line results.
//
// Usage:
//   req_if carries one transaction per character: byte_in, or end_of_input set
//   to close the stream (byte_in then ignored). rsp_if carries one transaction
//   per closed line: command letter, up to four numbers, their count, a status
//   (valid, error, ignored) and whether end of input closed the line.
//   Characters that do not close a line produce no response transaction.
// Path: a closing character passes the input register, then the result register,
//   before its result shows on rsp_if.
// Throughput: one character per cycle, save while a closing character stalls;
//   the per-character work is a classify, one times-ten add with overflow check, and a state update.
// Reset: synchronous, active high; clears the input and result registers and
//   returns the parser to the start of a line with all accumulators at zero.
//   req_if.ready stays low while reset is held.
// Stall: while a result waits on rsp_if, characters that close no line keep
//   flowing; a closing character holds in the input register until the result
//   register frees, and req_if.ready drops only then.
`default_nettype none

`include "command_line_tokenizer_core_macros.svh"

module command_line_tokenizer_core (
   input  wire logic  clock,
   input  wire logic  reset,
   ctk_req_if.sink    req_if,
   ctk_rsp_if.source  rsp_if
);

   localparam int Iw = ctk_pkg::IndexWidth;
   localparam int Nw = ctk_pkg::NumberWidth;

   // input register
   logic       item_valid_ff, item_valid_in;
   logic [7:0] item_byte_ff, item_byte_in;
   logic       item_end_ff, item_end_in;

   // parser state
   logic          at_line_start_ff, at_line_start_in;
   logic [7:0]    command_letter_ff, command_letter_in;
   logic          ignore_line_ff, ignore_line_in;
   logic          line_error_ff, line_error_in;
   logic          gap_seen_ff, gap_seen_in;
   logic [Iw-1:0] number_index_ff, number_index_in;
   logic [Nw-1:0] acc_ff [ctk_pkg::MaxNumbers];
   logic [Nw-1:0] acc_in [ctk_pkg::MaxNumbers];

   // result register
   logic                 rsp_valid_ff, rsp_valid_in;
   ctk_pkg::result_type  rsp_ff, rsp_in;

   ctk_pkg::char_class_type cls;
   logic          emit;
   logic [1:0]    emit_status;
   logic          emit_ended;
   logic          advance;
   logic          rsp_free;
   logic [Iw-1:0] index_eff;
   logic [Nw-1:0] acc_sel;
   logic [Nw-1:0] acc_next;
   logic          acc_overflow;
   logic [Nw-1:0] slot_value [ctk_pkg::OutSlots];

   ctk_char_class u_class (
      .ch  (item_byte_ff),
      .cls (cls)
   );

   ctk_digit_acc u_acc (
      .acc      (acc_sel),
      .digit    (cls.digit),
      .acc_next (acc_next),
      .overflow (acc_overflow)
   );

   // number slot that a digit lands in: open a new one after a gap
   always_comb begin
      index_eff = number_index_ff;
      if (gap_seen_ff && number_index_ff <= Iw'(ctk_pkg::MaxNumbers)) begin
         index_eff = number_index_ff + Iw'(1);
      end
      acc_sel = '0;
      for (int k = 0; k < ctk_pkg::MaxNumbers; k++) begin
         if (index_eff == Iw'(k + 1)) begin
            acc_sel = acc_ff[k];
         end
      end
   end

   // line parser: next state and whether this character closes a line
   always_comb begin
      at_line_start_in  = at_line_start_ff;
      command_letter_in = command_letter_ff;
      ignore_line_in    = ignore_line_ff;
      line_error_in     = line_error_ff;
      gap_seen_in       = gap_seen_ff;
      number_index_in   = number_index_ff;
      acc_in            = acc_ff;
      emit              = 1'b0;
      emit_status       = ctk_pkg::StatusIgnored;
      emit_ended        = item_end_ff;

      if (at_line_start_ff) begin
         if (item_end_ff || cls.is_newline) begin
            emit        = 1'b1;
            emit_status = ctk_pkg::StatusIgnored;
         end else begin
            at_line_start_in = 1'b0;
            ignore_line_in   = cls.is_hash;
            if (cls.is_alpha) begin
               command_letter_in = item_byte_ff;
            end else begin
               line_error_in = 1'b1;
            end
         end
      end else if (item_end_ff || cls.is_newline) begin
         emit = 1'b1;
         if (ignore_line_ff) begin
            emit_status = ctk_pkg::StatusIgnored;
         end else if (line_error_ff || item_end_ff) begin
            emit_status = ctk_pkg::StatusError;
         end else begin
            emit_status = ctk_pkg::StatusValid;
         end
      end else if (cls.is_blank) begin
         gap_seen_in = 1'b1;
      end else if (!cls.is_numeral || (!gap_seen_ff && number_index_ff == '0)) begin
         line_error_in = 1'b1;
      end else begin
         number_index_in = index_eff;
         gap_seen_in     = 1'b0;
         if (index_eff == '0 || index_eff > Iw'(ctk_pkg::MaxNumbers)) begin
            line_error_in = 1'b1;
         end else begin
            for (int k = 0; k < ctk_pkg::MaxNumbers; k++) begin
               if (index_eff == Iw'(k + 1)) begin
                  acc_in[k] = acc_next;
               end
            end
            if (acc_overflow) begin
               line_error_in = 1'b1;
            end
         end
      end

      // drop the line state once its line closes and its result is registered
      if (emit) begin
         at_line_start_in  = 1'b1;
         command_letter_in = '0;
         ignore_line_in    = 1'b0;
         line_error_in     = 1'b0;
         gap_seen_in       = 1'b0;
         number_index_in   = '0;
         for (int k = 0; k < ctk_pkg::MaxNumbers; k++) begin
            acc_in[k] = '0;
         end
      end
   end

   // result formatting: fields past the configured slots read zero
   always_comb begin
      for (int j = 0; j < ctk_pkg::OutSlots; j++) begin
         slot_value[j] = '0;
         if (j < ctk_pkg::MaxNumbers && emit_status == ctk_pkg::StatusValid) begin
            slot_value[j] = acc_ff[j];
         end
      end
      rsp_in.command_code = (emit_status == ctk_pkg::StatusValid) ? command_letter_ff : '0;
      rsp_in.value_one    = ctk_pkg::ValueWidth'(slot_value[0]);
      rsp_in.value_two    = ctk_pkg::ValueWidth'(slot_value[1]);
      rsp_in.value_three  = ctk_pkg::ValueWidth'(slot_value[2]);
      rsp_in.value_four   = ctk_pkg::ValueWidth'(slot_value[3]);
      rsp_in.value_count  = (emit_status == ctk_pkg::StatusValid)
                            ? 3'(number_index_ff) : 3'd0;
      rsp_in.line_status  = emit_status;
      rsp_in.input_ended  = emit_ended;
   end

   // flow control: only a line-closing character needs the result register
   always_comb begin
      rsp_free      = !rsp_valid_ff || rsp_if.ready;
      advance       = item_valid_ff && (!emit || rsp_free);
      req_if.ready  = !reset && (!item_valid_ff || advance);

      item_valid_in = item_valid_ff;
      item_byte_in  = item_byte_ff;
      item_end_in   = item_end_ff;
      if (req_if.ready) begin
         item_valid_in = req_if.valid;
         item_byte_in  = req_if.byte_in;
         item_end_in   = req_if.end_of_input;
      end

      rsp_valid_in = rsp_valid_ff;
      if (advance && emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff     <= 1'b0;
         rsp_valid_ff      <= 1'b0;
         at_line_start_ff  <= 1'b1;
         command_letter_ff <= '0;
         ignore_line_ff    <= 1'b0;
         line_error_ff     <= 1'b0;
         gap_seen_ff       <= 1'b0;
         number_index_ff   <= '0;
         for (int k = 0; k < ctk_pkg::MaxNumbers; k++) begin
            acc_ff[k] <= '0;
         end
      end else begin
         item_valid_ff <= item_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (advance) begin
            at_line_start_ff  <= at_line_start_in;
            command_letter_ff <= command_letter_in;
            ignore_line_ff    <= ignore_line_in;
            line_error_ff     <= line_error_in;
            gap_seen_ff       <= gap_seen_in;
            number_index_ff   <= number_index_in;
            acc_ff            <= acc_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      item_byte_ff <= item_byte_in;
      item_end_ff  <= item_end_in;
      if (advance && emit) begin
         rsp_ff <= rsp_in;
      end
   end

   always_comb begin
      rsp_if.valid        = rsp_valid_ff;
      rsp_if.command_code = rsp_ff.command_code;
      rsp_if.value_one    = rsp_ff.value_one;
      rsp_if.value_two    = rsp_ff.value_two;
      rsp_if.value_three  = rsp_ff.value_three;
      rsp_if.value_four   = rsp_ff.value_four;
      rsp_if.value_count  = rsp_ff.value_count;
      rsp_if.line_status  = rsp_ff.line_status;
      rsp_if.input_ended  = rsp_ff.input_ended;
   end

   // a non-valid line carries no letter and no count
   `CTK_ASSERT_IMPL(a_clear_on_reject, rsp_valid_ff && rsp_ff.line_status != ctk_pkg::StatusValid, rsp_ff.command_code == '0 && rsp_ff.value_count == '0)
   // number index never passes one beyond the slot count
   `CTK_ASSERT_IMPL(a_index_range, 1'b1, number_index_ff <= Iw'(ctk_pkg::MaxNumbers + 1))
   // a closed line puts the parser back at line start
   `CTK_ASSERT_NEXT(a_line_restart, advance && emit, at_line_start_ff && number_index_ff == '0)
   // a valid result never counts more numbers than there are slots
   `CTK_ASSERT_IMPL(a_count_range, rsp_valid_ff, rsp_ff.value_count <= 3'(ctk_pkg::MaxNumbers))

endmodule

`default_nettype wire

[rtl/ctk_char_class.sv]
// Character classifier: decode one byte into the classes the parser tests.
`default_nettype none

module ctk_char_class (
   input  wire logic [7:0]              ch,
   output ctk_pkg::char_class_type      cls
);

   always_comb begin
      cls.is_newline = (ch == ctk_pkg::ChNewline);
      cls.is_hash    = (ch == ctk_pkg::ChHash);
      cls.is_alpha   = (ch inside {[ctk_pkg::ChUpperA:ctk_pkg::ChUpperZ],
                                   [ctk_pkg::ChLowerA:ctk_pkg::ChLowerZ]});
      cls.is_blank   = (ch inside {ctk_pkg::ChSpace, ctk_pkg::ChTab, ctk_pkg::ChVtab,
                                   ctk_pkg::ChFeed, ctk_pkg::ChReturn});
      cls.is_numeral = (ch inside {[ctk_pkg::ChZero:ctk_pkg::ChNine]});
      cls.digit      = 4'(ch - ctk_pkg::ChZero);
   end

endmodule

`default_nettype wire

[rtl/ctk_digit_acc.sv]
// Decimal accumulate step: acc * 10 + digit, saturating at the number limit.
`default_nettype none

module ctk_digit_acc (
   input  wire logic [ctk_pkg::NumberWidth-1:0] acc,
   input  wire logic [3:0]                      digit,
   output logic      [ctk_pkg::NumberWidth-1:0] acc_next,
   output logic                                 overflow
);

   logic [ctk_pkg::ProductWidth-1:0] wide_acc;
   logic [ctk_pkg::ProductWidth-1:0] sum;

   always_comb begin
      wide_acc = ctk_pkg::ProductWidth'(acc);
      // times ten as two shifted adds
      sum      = (wide_acc << 3) + (wide_acc << 1) + ctk_pkg::ProductWidth'(digit);
      overflow = (sum[ctk_pkg::ProductWidth-1:ctk_pkg::NumberWidth] != '0);
      acc_next = overflow ? ctk_pkg::NumberLimit : sum[ctk_pkg::NumberWidth-1:0];
   end

endmodule

`default_nettype wire

[test/command_line_tokenizer_core_tb.sv]
// Testbench for the command line tokenizer: line-level checks against a built-in parser model.
`timescale 1ns / 1ps

module command_line_tokenizer_core_tb;

   // One row of the directed table: a character, plus the line result where it is
   // obvious (ignored and error lines carry nothing but status and end flag).
   typedef struct packed {
      logic [7:0] ch;
      logic       ended;
      logic       typed;
      logic [1:0] status;
      logic       closed_by_end;
   } table_row_type;

   // One request transaction as the sender sees it.
   typedef struct {
      logic [7:0]          byte_val;
      logic                ended;
      bit                  typed;
      ctk_pkg::result_type typed_line;
   } char_item_type;

   localparam int DirectedRows   = 26;
   localparam int RandomChars    = 1500;
   localparam int LongHoldCycles = 400;
   localparam int LongHoldAfter  = 400;
   localparam int WatchdogLimit  = 5000;
   localparam int ReportLimit    = 10;

   localparam logic [63:0] ValueCap = (64'd1 << ctk_pkg::NumberWidth) - 64'd1;

   // Directed lines: end at line start, empty line, bad first character, digit
   // glued to the letter, stray character, a full line using space, tab, vtab and feed,
   // a comment with a high byte closed by end of input, end of input mid-line.
   localparam table_row_type DirectedTable [DirectedRows] = '{
      '{8'hA5,              1'b1, 1'b1, ctk_pkg::StatusIgnored, 1'b1},
      '{ctk_pkg::ChNewline, 1'b0, 1'b1, ctk_pkg::StatusIgnored, 1'b0},
      '{ctk_pkg::ChZero,    1'b0, 1'b0, ctk_pkg::StatusValid,   1'b0},
      '{ctk_pkg::ChNewline, 1'b0, 1'b1, ctk_pkg::StatusError,   1'b0},
      '{"A",                1'b0, 1'b0, ctk_pkg::StatusValid,   1'b0},
      '{"7",                1'b0, 1'b0, ctk_pkg::StatusValid,   1'b0},
      '{ctk_pkg::ChNewline, 1'b0, 1'b1, ctk_pkg::StatusError,   1'b0},
      '{"q",                1'b0, 1'b0, ctk_pkg::StatusValid,   1'b0},
      '{ctk_pkg::ChReturn,  1'b0, 1'b0, ctk_pkg::StatusValid,   1'b0},
      '{"x",                1'b0, 1'b0, ctk_pkg::StatusValid,   1'b0},
      '{ctk_pkg::ChNewline, 1'b0, 1'b1, ctk_pkg::StatusError,   1'b0},
      '{"Z",                1'b0, 1'b0, ctk_pkg::StatusValid,   1'b0},
      '{ctk_pkg::ChSpace,   1'b0, 1'b0, ctk_pkg::StatusValid,   1'b0},
      '{"1",                1'b0, 1'b0, ctk_pkg::StatusValid,   1'b0},
      '{ctk_pkg::ChTab,     1'b0, 1'b0, ctk_pkg::StatusValid,   1'b0},
      '{"2",                1'b0, 1'b0, ctk_pkg::StatusValid,   1'b0},
      '{ctk_pkg::ChVtab,    1'b0, 1'b0, ctk_pkg::StatusValid,   1'b0},
      '{"3",                1'b0, 1'b0, ctk_pkg::StatusValid,   1'b0},
      '{ctk_pkg::ChFeed,    1'b0, 1'b0, ctk_pkg::StatusValid,   1'b0},
      '{"4",                1'b0, 1'b0, ctk_pkg::StatusValid,   1'b0},
      '{ctk_pkg::ChNewline, 1'b0, 1'b0, ctk_pkg::StatusValid,   1'b0},
      '{ctk_pkg::ChHash,    1'b0, 1'b0, ctk_pkg::StatusValid,   1'b0},
      '{8'hFF,              1'b0, 1'b0, ctk_pkg::StatusValid,   1'b0},
      '{8'h00,              1'b1, 1'b1, ctk_pkg::StatusIgnored, 1'b1},
      '{"a",                1'b0, 1'b0, ctk_pkg::StatusValid,   1'b0},
      '{8'h5A,              1'b1, 1'b1, ctk_pkg::StatusError,   1'b1}
   };

   logic clock = 1'b0;
   logic reset;

   ctk_req_if req_chan ();
   ctk_rsp_if rsp_chan ();

   command_line_tokenizer_core i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_chan),
      .rsp_if (rsp_chan)
   );

   // Parser model state, one copy of what the block keeps per line.
   bit          line_fresh;
   logic [7:0]  letter_held;
   bit          comment_line;
   bit          line_bad;
   bit          blank_pending;
   logic [2:0]  num_slot;
   logic [63:0] number_acc [ctk_pkg::MaxNumbers];

   logic [7:0]    blank_chars [5] = '{ctk_pkg::ChSpace, ctk_pkg::ChTab, ctk_pkg::ChVtab,
                                      ctk_pkg::ChFeed, ctk_pkg::ChReturn};
   char_item_type       stim_chars [$];
   char_item_type       current_char;
   ctk_pkg::result_type expected_lines [$];

   int  mismatch_count = 0;
   int  accepted_chars = 0;
   int  idle_cycles    = 0;
   bit  long_hold_done = 1'b0;

   // ---------------------------------------------------------------------------
   // Parser model
   // ---------------------------------------------------------------------------

   function automatic void clear_line_state();
      line_fresh    = 1'b1;
      letter_held   = '0;
      comment_line  = 1'b0;
      line_bad      = 1'b0;
      blank_pending = 1'b0;
      num_slot      = '0;
      foreach (number_acc[k]) number_acc[k] = '0;
   endfunction

   function automatic logic [1:0] line_status_now();
      if (comment_line) return ctk_pkg::StatusIgnored;
      return line_bad ? ctk_pkg::StatusError : ctk_pkg::StatusValid;
   endfunction

   // Build the line result, then drop back to line start.
   function automatic void close_line(input logic [1:0] status, input logic ended,
                                      output ctk_pkg::result_type line_out);
      line_out = '0;
      if (status == ctk_pkg::StatusValid) begin
         line_out.command_code = letter_held;
         line_out.value_one    = number_acc[0][ctk_pkg::ValueWidth-1:0];
         line_out.value_two    = number_acc[1][ctk_pkg::ValueWidth-1:0];
         line_out.value_three  = number_acc[2][ctk_pkg::ValueWidth-1:0];
         line_out.value_four   = number_acc[3][ctk_pkg::ValueWidth-1:0];
         line_out.value_count  = num_slot;
      end
      line_out.line_status = status;
      line_out.input_ended = ended;
      clear_line_state();
   endfunction

   // Advance the parser by one character; return 1 when a line closes.
   function automatic bit parse_char(input logic [7:0] ch, input logic ended,
                                     output ctk_pkg::result_type line_out);
      logic [63:0] digit;
      line_out = '0;
      if (line_fresh) begin
         if (ended) begin
            close_line(ctk_pkg::StatusIgnored, 1'b1, line_out);
            return 1'b1;
         end
         if (ch == ctk_pkg::ChNewline) begin
            close_line(ctk_pkg::StatusIgnored, 1'b0, line_out);
            return 1'b1;
         end
         line_fresh = 1'b0;
         if (ch == ctk_pkg::ChHash) comment_line = 1'b1;
         if ((ch >= ctk_pkg::ChUpperA && ch <= ctk_pkg::ChUpperZ) ||
             (ch >= ctk_pkg::ChLowerA && ch <= ctk_pkg::ChLowerZ))
            letter_held = ch;
         else
            line_bad = 1'b1;
         return 1'b0;
      end
      if (ended) begin
         line_bad = 1'b1;
         close_line(line_status_now(), 1'b1, line_out);
         return 1'b1;
      end
      if (ch == ctk_pkg::ChNewline) begin
         close_line(line_status_now(), 1'b0, line_out);
         return 1'b1;
      end
      if (ch == ctk_pkg::ChSpace || ch == ctk_pkg::ChTab || ch == ctk_pkg::ChVtab ||
          ch == ctk_pkg::ChFeed || ch == ctk_pkg::ChReturn) begin
         blank_pending = 1'b1;
      end else if (ch < ctk_pkg::ChZero || ch > ctk_pkg::ChNine ||
                   (!blank_pending && num_slot == 0)) begin
         line_bad = 1'b1;
      end else begin
         if (blank_pending) begin
            if (num_slot <= ctk_pkg::MaxNumbers) num_slot = num_slot + 3'd1;
            blank_pending = 1'b0;
         end
         digit = 64'(ch - ctk_pkg::ChZero);
         if (num_slot < 1 || num_slot > ctk_pkg::MaxNumbers) begin
            line_bad = 1'b1;
         end else if (number_acc[num_slot-1] > (ValueCap - digit) / 64'd10) begin
            // saturate and flag the line
            number_acc[num_slot-1] = ValueCap;
            line_bad = 1'b1;
         end else begin
            number_acc[num_slot-1] = number_acc[num_slot-1] * 64'd10 + digit;
         end
      end
      return 1'b0;
   endfunction

   // ---------------------------------------------------------------------------
   // Stimulus construction
   // ---------------------------------------------------------------------------

   function automatic void push_char(input logic [7:0] ch, input logic ended);
      char_item_type item;
      item.byte_val   = ch;
      item.ended      = ended;
      item.typed      = 1'b0;
      item.typed_line = '0;
      stim_chars.push_back(item);
   endfunction

   function automatic logic [7:0] random_letter();
      if ($urandom_range(0, 1) == 1) return 8'(ctk_pkg::ChUpperA + $urandom_range(0, 25));
      return 8'(ctk_pkg::ChLowerA + $urandom_range(0, 25));
   endfunction

   function automatic void push_blanks();
      repeat ($urandom_range(1, 3)) push_char(blank_chars[$urandom_range(0, 4)], 1'b0);
   endfunction

   function automatic void push_decimal(input logic [63:0] v);
      string digits_text;
      digits_text = $sformatf("%0d", v);
      for (int i = 0; i < digits_text.len(); i++) push_char(digits_text[i], 1'b0);
   endfunction

   // Pick a number: zeros with leading zeros, values at, just below and just past the cap,
   // long overflowing strings, full 32-bit values and small ones.
   function automatic void push_value();
      case ($urandom_range(0, 7))
         0: begin
            repeat ($urandom_range(1, 3)) push_char(ctk_pkg::ChZero, 1'b0);
            if ($urandom_range(0, 1) == 1) push_decimal(64'($urandom_range(0, 99)));
         end
         1: push_decimal(ValueCap - 64'($urandom_range(0, 5)));
         2: push_decimal(ValueCap + 64'($urandom_range(1, 9)));
         3: begin
            push_char(8'(ctk_pkg::ChZero + $urandom_range(1, 9)), 1'b0);
            repeat ($urandom_range(10, 19))
               push_char(8'(ctk_pkg::ChZero + $urandom_range(0, 9)), 1'b0);
         end
         4: push_decimal({32'd0, $urandom()});
         default: push_decimal(64'($urandom_range(0, 999)));
      endcase
   endfunction

   // Close mostly by newline, now and then by end of input with a junk byte.
   function automatic void push_closer();
      if ($urandom_range(0, 24) == 0) push_char(8'($urandom_range(0, 255)), 1'b1);
      else push_char(ctk_pkg::ChNewline, 1'b0);
   endfunction

   function automatic void add_random_line();
      int unsigned pick;
      int unsigned count;
      pick = $urandom_range(0, 99);
      if (pick < 75) begin
         // well-formed line; the top slice carries one number too many
         push_char(random_letter(), 1'b0);
         count = (pick >= 70) ? ctk_pkg::MaxNumbers + 1 : $urandom_range(0, ctk_pkg::MaxNumbers);
         repeat (count) begin
            push_blanks();
            push_value();
         end
         if ($urandom_range(0, 3) == 0) push_blanks();
         push_closer();
      end else if (pick < 80) begin
         // stray byte inside an otherwise good line
         push_char(random_letter(), 1'b0);
         push_blanks();
         push_char(8'($urandom_range(0, 255)), 1'b0);
         push_value();
         push_closer();
      end else if (pick < 85) begin
         // noise from the first position on
         repeat ($urandom_range(1, 8)) push_char(8'($urandom_range(0, 255)), 1'b0);
         push_closer();
      end else if (pick < 90) begin
         // comment line with arbitrary content
         push_char(ctk_pkg::ChHash, 1'b0);
         repeat ($urandom_range(0, 8)) push_char(8'($urandom_range(0, 255)), 1'b0);
         push_closer();
      end else if (pick < 94) begin
         push_char(ctk_pkg::ChNewline, 1'b0);
      end else if (pick < 96) begin
         push_char(8'($urandom_range(0, 255)), 1'b1);
      end else begin
         // digit glued to the command letter
         push_char(random_letter(), 1'b0);
         push_char(8'(ctk_pkg::ChZero + $urandom_range(0, 9)), 1'b0);
         if ($urandom_range(0, 1) == 1) begin
            push_blanks();
            push_value();
         end
         push_closer();
      end
   endfunction

   // ---------------------------------------------------------------------------
   // Clock and reset
   // ---------------------------------------------------------------------------

   always #5 clock = ~clock;

   initial begin
      reset                 <= 1'b1;
      req_chan.valid        <= 1'b0;
      req_chan.byte_in      <= '0;
      req_chan.end_of_input <= 1'b0;
      clear_line_state();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
   end

   // ---------------------------------------------------------------------------
   // Sender: bursts of characters with random gaps, two drain pauses
   // ---------------------------------------------------------------------------

   // Present one character and hold it until the block takes it.
   task automatic offer_char(input char_item_type item);
      current_char          <= item;
      req_chan.valid        <= 1'b1;
      req_chan.byte_in      <= item.byte_val;
      req_chan.end_of_input <= item.ended;
      do @(posedge clock); while (!(req_chan.valid && req_chan.ready));
   endtask

   // Drop valid and wait until every predicted line has come back.
   task automatic wait_for_lines();
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (expected_lines.size() != 0);
   endtask

   initial begin
      char_item_type row_item;
      int unsigned   burst_left;
      int unsigned   gap;
      burst_left = 0;

      // Walk the directed table into the stimulus queue.
      for (int r = 0; r < DirectedRows; r++) begin
         row_item.byte_val               = DirectedTable[r].ch;
         row_item.ended                  = DirectedTable[r].ended;
         row_item.typed                  = DirectedTable[r].typed;
         row_item.typed_line             = '0;
         row_item.typed_line.line_status = DirectedTable[r].status;
         row_item.typed_line.input_ended = DirectedTable[r].closed_by_end;
         stim_chars.push_back(row_item);
      end
      while (stim_chars.size() < DirectedRows + RandomChars) add_random_line();

      do @(posedge clock); while (reset);

      for (int idx = 0; idx < stim_chars.size(); idx++) begin
         // Open a new burst with a gap in front of it; a quarter of bursts run
         // straight on from the last one.
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap != 0) begin
               req_chan.valid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
         burst_left--;
         offer_char(stim_chars[idx]);
         if (idx == DirectedRows - 1 || idx == DirectedRows + 700) begin
            wait_for_lines();
            burst_left = 0;
         end
      end

      // Drain, then let the result register show anything extra before the verdict.
      wait_for_lines();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0 && expected_lines.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   // ---------------------------------------------------------------------------
   // Receiver: ready pattern of its own, with one long hold-off
   // ---------------------------------------------------------------------------

   initial begin
      int unsigned mode;
      int unsigned stretch;
      rsp_chan.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         // Hold off long enough for a result to park, a closing character to
         // sit in the input register, and req ready to drop.
         if (!long_hold_done && accepted_chars >= LongHoldAfter) begin
            rsp_chan.ready <= 1'b0;
            repeat (LongHoldCycles) @(posedge clock);
            long_hold_done = 1'b1;
         end
         mode    = $urandom_range(0, 3);
         stretch = $urandom_range(8, 60);
         for (int c = 0; c < stretch; c++) begin
            case (mode)
               0: rsp_chan.ready <= 1'b1;
               1: rsp_chan.ready <= ($urandom_range(0, 1) == 1);
               2: rsp_chan.ready <= (c % 4 == 3);
               default: rsp_chan.ready <= ($urandom_range(0, 3) != 0);
            endcase
            @(posedge clock);
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Monitor and checker
   // ---------------------------------------------------------------------------

   function automatic void note_mismatch(input string what, input ctk_pkg::result_type want,
                                         input ctk_pkg::result_type got);
      mismatch_count++;
      if (mismatch_count <= ReportLimit) begin
         $display("%s: expected code %h vals %h %h %h %h count %0d status %0d end %0b",
                  what, want.command_code, want.value_one, want.value_two,
                  want.value_three, want.value_four, want.value_count,
                  want.line_status, want.input_ended);
         $display("   got code %h vals %h %h %h %h count %0d status %0d end %0b",
                  got.command_code, got.value_one, got.value_two, got.value_three,
                  got.value_four, got.value_count, got.line_status, got.input_ended);
      end
   endfunction

   always @(posedge clock) begin
      ctk_pkg::result_type predicted;
      ctk_pkg::result_type got;
      ctk_pkg::result_type want;
      if (!reset) begin
         // Predict on every accepted character; a typed row overrides the model.
         if (req_chan.valid && req_chan.ready) begin
            accepted_chars++;
            if (parse_char(current_char.byte_val, current_char.ended, predicted))
               expected_lines.push_back(current_char.typed ? current_char.typed_line
                                                            : predicted);
         end
         // Compare each returned line with the oldest prediction.
         if (rsp_chan.valid && rsp_chan.ready) begin
            got = {rsp_chan.command_code, rsp_chan.value_one, rsp_chan.value_two,
                   rsp_chan.value_three, rsp_chan.value_four, rsp_chan.value_count,
                   rsp_chan.line_status, rsp_chan.input_ended};
            if (expected_lines.size() == 0) begin
               note_mismatch("unexpected line", '0, got);
            end else begin
               want = expected_lines.pop_front();
               if (got.command_code !== want.command_code ||
                   got.value_one !== want.value_one ||
                   got.value_two !== want.value_two ||
                   got.value_three !== want.value_three ||
                   got.value_four !== want.value_four ||
                   got.value_count !== want.value_count ||
                   got.line_status !== want.line_status ||
                   got.input_ended !== want.input_ended)
                  note_mismatch("line differs", want, got);
            end
         end
      end
   end

   // Watchdog: end the run when neither channel moves for too long.
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WatchdogLimit) begin
            $display("Mismatches found");
            $finish;
         end
      end
   end

endmodule
